@@ src/vau_pkg.sv @@
`timescale 1ns / 1ps
package vau_pkg;

  localparam int DW  = 32;
  localparam int SQW = 66;

  localparam logic [DW-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    K_ADD   = 4'd0,
    K_SUB   = 4'd1,
    K_MUL   = 4'd2,
    K_DIV   = 4'd3,
    K_SCALE = 4'd4,
    K_DIVS  = 4'd5,
    K_NEG   = 4'd6,
    K_LEN   = 4'd7,
    K_NORM  = 4'd8,
    K_DIST  = 4'd9
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic [2:0][DW-1:0]          a;
    logic [2:0][DW-1:0]          b;
    logic [DW-1:0]               s;
  } req_t;

  // carried alongside the square root
  typedef struct packed {
    kind_t                       kind;
    logic [2:0][DW-1:0]          a;
    logic [2:0][DW:0]            den;
    logic [2:0][DW-1:0]          res;
    logic                        sat;
    logic                        over;
  } side1_t;

  // carried alongside the dividers
  typedef struct packed {
    kind_t                       kind;
    logic [2:0][DW-1:0]          res;
    logic                        sat;
    logic                        over;
    logic [DW-1:0]               root;
  } side2_t;

endpackage

@@ src/vau_if.sv @@
`timescale 1ns / 1ps
interface vau_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] az;
  logic signed [31:0] bx;
  logic signed [31:0] by_comp;
  logic signed [31:0] bz;
  logic signed [31:0] scalar_in;

  modport source (output valid, kind, ax, ay, az, bx, by_comp, bz, scalar_in,
                  input ready);
  modport sink (input valid, kind, ax, ay, az, bx, by_comp, bz, scalar_in,
                output ready);
endinterface

interface vau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic [31:0]        magnitude;
  logic               div_zero;
  logic               saturated;

  modport source (output valid, res_x, res_y, res_z, magnitude, div_zero, saturated,
                  input ready);
  modport sink (input valid, res_x, res_y, res_z, magnitude, div_zero, saturated,
                output ready);
endinterface

@@ src/vau_lane.sv @@
`timescale 1ns / 1ps
module vau_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   adv,
  input  vau_pkg::kind_t         kind,
  input  logic [31:0]            a,
  input  logic [31:0]            b,
  input  logic [31:0]            s,
  output logic [31:0]            res,
  output logic                   sat,
  output logic [vau_pkg::SQW-1:0] sq
);
  import vau_pkg::*;

  kind_t                kind_b_r;
  logic [DW-1:0]        simple_r, simple_nxt;
  logic                 simple_sat_r, simple_sat_nxt;
  logic signed [63:0]   prod_r, prod_nxt;
  logic [SQW-1:0]       sq_r, sq_nxt;
  logic [DW-1:0]        res_r, res_nxt;
  logic                 sat_r, sat_nxt;

  logic signed [DW:0]   sum, dif, neg, pick, sqop;
  logic [DW:0]          mag;
  logic signed [DW-1:0] op2;
  logic signed [63:0]   sh;

  always_comb begin
    sum  = $signed({a[DW-1], a}) + $signed({b[DW-1], b});
    dif  = $signed({a[DW-1], a}) - $signed({b[DW-1], b});
    neg  = -$signed({a[DW-1], a});
    case (kind)
      K_ADD:   pick = sum;
      K_SUB:   pick = dif;
      K_NEG:   pick = neg;
      default: pick = '0;
    endcase
    simple_sat_nxt = pick[DW] != pick[DW-1];
    simple_nxt     = simple_sat_nxt ? (pick[DW] ? S32_MIN : S32_MAX) : pick[DW-1:0];

    op2      = (kind == K_SCALE) ? $signed(s) : $signed(b);
    prod_nxt = $signed(a) * op2;

    sqop   = (kind == K_DIST) ? dif : $signed({a[DW-1], a});
    mag    = sqop[DW] ? (~sqop + 1'b1) : sqop;
    sq_nxt = SQW'(mag) * SQW'(mag);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_b_r     <= kind;
      simple_r     <= simple_nxt;
      simple_sat_r <= simple_sat_nxt;
      prod_r       <= prod_nxt;
      sq_r         <= sq_nxt;
    end
  end

  // floor shift of the product, then clip
  always_comb begin
    sh = prod_r >>> FRAC_BITS;
    case (kind_b_r)
      K_ADD, K_SUB, K_NEG: begin
        res_nxt = simple_r;
        sat_nxt = simple_sat_r;
      end
      K_MUL, K_SCALE: begin
        sat_nxt = !((&sh[63:DW-1]) || !(|sh[63:DW-1]));
        res_nxt = sat_nxt ? (sh[63] ? S32_MIN : S32_MAX) : sh[DW-1:0];
      end
      default: begin
        res_nxt = '0;
        sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;
  assign sq  = sq_r;

endmodule

@@ src/vau_sqrt.sv @@
`timescale 1ns / 1ps
module vau_sqrt (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import vau_pkg::*;

  localparam int NS = 32;

  logic [35:0] rem_r  [NS];
  logic [35:0] rem_nxt[NS];
  logic [31:0] rt_r   [NS];
  logic [31:0] rt_nxt [NS];
  logic [63:0] n_r    [NS];
  logic [63:0] n_nxt  [NS];

  // one root bit per stage, restoring
  always_comb begin
    logic [35:0] rem_i, r2, trial;
    logic [31:0] rt_i;
    logic [63:0] n_i;
    logic        ge;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rem_i = '0;
        rt_i  = '0;
        n_i   = rad;
      end else begin
        rem_i = rem_r[k-1];
        rt_i  = rt_r[k-1];
        n_i   = n_r[k-1];
      end
      r2         = {rem_i[33:0], n_i[63:62]};
      trial      = {2'b00, rt_i, 2'b01};
      ge         = r2 >= trial;
      rem_nxt[k] = ge ? r2 - trial : r2;
      rt_nxt[k]  = {rt_i[30:0], ge};
      n_nxt[k]   = {n_i[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        rem_r[k] <= rem_nxt[k];
        rt_r[k]  <= rt_nxt[k];
        n_r[k]   <= n_nxt[k];
      end
    end
  end

  assign root = rt_r[NS-1];

endmodule

@@ src/vau_div.sv @@
`timescale 1ns / 1ps
module vau_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] num,
  input  logic [32:0] den,
  output logic [31:0] quo,
  output logic        sat,
  output logic        dz
);
  import vau_pkg::*;

  localparam int NW = DW + FRAC_BITS;

  logic [33:0]   rem_r  [NW];
  logic [33:0]   rem_nxt[NW];
  logic [NW-1:0] nb_r   [NW];
  logic [NW-1:0] nb_nxt [NW];
  logic [NW-1:0] q_r    [NW];
  logic [NW-1:0] q_nxt  [NW];
  logic [32:0]   d_r    [NW];
  logic [32:0]   d_nxt  [NW];
  logic [NW-1:0] neg_r, dz_r, nneg_r, nzero_r;
  logic [NW-1:0] neg_nxt, dz_nxt, nneg_nxt, nzero_nxt;

  logic [DW-1:0] mag_a;
  logic [32:0]   mag_d;

  logic [DW-1:0] quo_r, quo_nxt;
  logic          sat_r, sat_nxt, dz_o_r;
  logic [NW-1:0] qf;

  always_comb begin
    logic [33:0]   rem_i, r2;
    logic [NW-1:0] nb_i, q_i;
    logic [32:0]   d_i;
    logic          ge;
    mag_a = num[DW-1] ? (~num + 1'b1) : num;
    mag_d = den[32] ? (~den + 1'b1) : den;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        rem_i        = '0;
        nb_i         = {mag_a, {FRAC_BITS{1'b0}}};
        q_i          = '0;
        d_i          = mag_d;
        neg_nxt[k]   = num[DW-1] ^ den[32];
        dz_nxt[k]    = den == '0;
        nneg_nxt[k]  = num[DW-1];
        nzero_nxt[k] = num == '0;
      end else begin
        rem_i        = rem_r[k-1];
        nb_i         = nb_r[k-1];
        q_i          = q_r[k-1];
        d_i          = d_r[k-1];
        neg_nxt[k]   = neg_r[k-1];
        dz_nxt[k]    = dz_r[k-1];
        nneg_nxt[k]  = nneg_r[k-1];
        nzero_nxt[k] = nzero_r[k-1];
      end
      r2         = {rem_i[32:0], nb_i[NW-1]};
      ge         = r2 >= {1'b0, d_i};
      rem_nxt[k] = ge ? r2 - {1'b0, d_i} : r2;
      nb_nxt[k]  = nb_i << 1;
      q_nxt[k]   = {q_i[NW-2:0], ge};
      d_nxt[k]   = d_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NW; k++) begin
        rem_r[k] <= rem_nxt[k];
        nb_r[k]  <= nb_nxt[k];
        q_r[k]   <= q_nxt[k];
        d_r[k]   <= d_nxt[k];
      end
      neg_r   <= neg_nxt;
      dz_r    <= dz_nxt;
      nneg_r  <= nneg_nxt;
      nzero_r <= nzero_nxt;
    end
  end

  // sign, clip, and the divide-by-zero answer
  always_comb begin
    qf      = q_r[NW-1];
    sat_nxt = 1'b0;
    if (dz_r[NW-1]) begin
      quo_nxt = nneg_r[NW-1] ? S32_MIN : (nzero_r[NW-1] ? '0 : S32_MAX);
    end else if (!neg_r[NW-1]) begin
      sat_nxt = |qf[NW-1:DW-1];
      quo_nxt = sat_nxt ? S32_MAX : qf[DW-1:0];
    end else begin
      sat_nxt = (|qf[NW-1:DW]) || (qf[DW-1] && (|qf[DW-2:0]));
      quo_nxt = sat_nxt ? S32_MIN : (~qf[DW-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quo_r  <= quo_nxt;
      sat_r  <= sat_nxt;
      dz_o_r <= dz_r[NW-1];
    end
  end

  assign quo = quo_r;
  assign sat = sat_r;
  assign dz  = dz_o_r;

endmodule

@@ src/vec3_alu_normalize.sv @@
`timescale 1ns / 1ps
// Fixed point, Q16.16 at the default FRAC_BITS. Throughput: one request per cycle
// unless stalled; every stage is a register, no shared unit.
// Whole pipeline stalls as one when the result register is full and not taken.
// Latency is set by the 32-stage square root followed by the bit-per-stage dividers.
// Reset (rst_n low, synchronous) clears the valid chain only; data regs keep garbage.
module vec3_alu_normalize #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  vau_in_if.sink     in_if,
  vau_out_if.source  out_if
);
  import vau_pkg::*;

  localparam int NW     = DW + FRAC_BITS;
  localparam int SQ_LAT = 32;        // square root stages
  localparam int DV_LAT = NW + 1;    // divider stages plus its clip register
  localparam int LAT    = 3 + SQ_LAT + DV_LAT + 1;

  // Pipeline moves only when the output slot is free or being drained.
  logic adv;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign adv         = !vld_r[LAT-1] || out_if.ready;
  assign in_if.ready = adv;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_if.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // T1: request capture, then two delay regs to line up with the lanes
  req_t req1_r, req2_r, req3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      req1_r.kind <= kind_t'(in_if.kind);
      req1_r.a    <= {in_if.az, in_if.ay, in_if.ax};
      req1_r.b    <= {in_if.bz, in_if.by_comp, in_if.bx};
      req1_r.s    <= in_if.scalar_in;
      req2_r      <= req1_r;
      req3_r      <= req2_r;
    end
  end

  // Three lanes: add/sub/neg, product, square (T2) and clipped result (T3)
  logic [2:0][DW-1:0]  lane_res;
  logic [2:0]          lane_sat;
  logic [2:0][SQW-1:0] lane_sq;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .adv  (adv),
      .kind (req1_r.kind),
      .a    (req1_r.a[i]),
      .b    (req1_r.b[i]),
      .s    (req1_r.s),
      .res  (lane_res[i]),
      .sat  (lane_sat[i]),
      .sq   (lane_sq[i])
    );
  end

  // Merge: sum of the three squares (T3); bits above 63 mean distance overflow
  logic [SQW+1:0] sumsq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sumsq_r <= (SQW+2)'(lane_sq[0]) + (SQW+2)'(lane_sq[1]) + (SQW+2)'(lane_sq[2]);
    end
  end

  logic [DW-1:0] root;

  vau_sqrt u_sqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  (sumsq_r[63:0]),
    .root (root)
  );

  // Side data follows the root; divisor for div/divscalar picked here
  side1_t side1_in;
  side1_t side1_r [SQ_LAT];

  always_comb begin
    side1_in.kind = req3_r.kind;
    side1_in.a    = req3_r.a;
    for (int i = 0; i < 3; i++) begin
      side1_in.den[i] = (req3_r.kind == K_DIVS) ? {req3_r.s[DW-1], req3_r.s}
                                                 : {req3_r.b[i][DW-1], req3_r.b[i]};
    end
    side1_in.res  = lane_res;
    side1_in.sat  = |lane_sat;
    side1_in.over = |sumsq_r[SQW+1:64];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r[0] <= side1_in;
      for (int k = 1; k < SQ_LAT; k++) begin
        side1_r[k] <= side1_r[k-1];
      end
    end
  end

  // Dividers: normalize divides by the root just produced
  side1_t        s1;
  logic [2:0][DW-1:0] quo;
  logic [2:0]    dsat, dzero;

  assign s1 = side1_r[SQ_LAT-1];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .adv (adv),
      .num (s1.a[i]),
      .den ((s1.kind == K_NORM) ? {1'b0, root} : s1.den[i]),
      .quo (quo[i]),
      .sat (dsat[i]),
      .dz  (dzero[i])
    );
  end

  side2_t side2_in;
  side2_t side2_r [DV_LAT];

  always_comb begin
    side2_in.kind = s1.kind;
    side2_in.res  = s1.res;
    side2_in.sat  = s1.sat;
    side2_in.over = s1.over;
    side2_in.root = root;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r[0] <= side2_in;
      for (int k = 1; k < DV_LAT; k++) begin
        side2_r[k] <= side2_r[k-1];
      end
    end
  end

  // Final select into the output register
  side2_t             s2;
  logic [2:0][DW-1:0] res_nxt, res_r;
  logic [DW-1:0]      mag_nxt, mag_r;
  logic               dz_nxt, dz_r, sat_nxt, sat_r;

  assign s2 = side2_r[DV_LAT-1];

  always_comb begin
    res_nxt = '0;
    mag_nxt = '0;
    dz_nxt  = 1'b0;
    sat_nxt = 1'b0;
    case (s2.kind)
      K_ADD, K_SUB, K_MUL, K_SCALE, K_NEG: begin
        res_nxt = s2.res;
        sat_nxt = s2.sat;
      end
      K_DIV, K_DIVS, K_NORM: begin
        res_nxt = quo;
        sat_nxt = |dsat;
        dz_nxt  = |dzero;
      end
      K_LEN: begin
        mag_nxt = s2.root;
      end
      K_DIST: begin
        mag_nxt = s2.over ? '1 : s2.root;
        sat_nxt = s2.over;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      mag_r <= mag_nxt;
      dz_r  <= dz_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_if.valid     = vld_r[LAT-1];
  assign out_if.res_x     = res_r[0];
  assign out_if.res_y     = res_r[1];
  assign out_if.res_z     = res_r[2];
  assign out_if.magnitude = mag_r;
  assign out_if.div_zero  = dz_r;
  assign out_if.saturated = sat_r;

endmodule
